>>> src/set_pkg.sv
// Shared types and constants for the 3x3 Sobel edge/threshold block.
// Used by the front pipeline, job queue, result emitter and top level.
`timescale 1ns / 1ps

package set_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int THR_W      = 11;
    localparam int SUM_W      = 12;     // 3*blue + 6*green + red, at most 2550
    localparam int GRAD_W     = 12;     // signed Sobel response, |g| <= 1020
    localparam int SQ_W       = 2 * THR_W;

    // floor(x / 10) for x <= 2550 as (x * 6554) >> 16
    localparam logic [12:0] GREY_RECIP = 13'd6554;
    localparam int          GREY_SHIFT = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_MODE      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd3;

    // edge modes
    localparam logic [1:0] MODE_ROW  = 2'd0;
    localparam logic [1:0] MODE_MAG  = 2'd1;
    localparam logic [1:0] MODE_COL  = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    localparam logic [PIX_W-1:0] PIX_WHITE = 8'd255;
    localparam logic [PIX_W-1:0] PIX_BLACK = 8'd0;

    localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 13'd640;
    localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic [1:0]            RST_EDGE_MODE    = MODE_MAG;
    localparam logic [THR_W-1:0]      RST_THRESHOLD    = 11'd80;

    // job queue between front and back
    localparam int JQ_DEPTH = 8;
    localparam int JQ_AW    = $clog2(JQ_DEPTH);
    localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);

    typedef struct packed {
        logic [CFG_DATA_W-1:0] frame_width;
        logic [CFG_DATA_W-1:0] frame_height;
        logic [1:0]            edge_mode;
        logic [THR_W-1:0]      edge_threshold;
    } t_cfg;

    // one classified pixel: an interior result for (row-1, col-1) and/or
    // a border result for (row, col)
    typedef struct packed {
        logic               has_int;
        logic               has_bord;
        logic               last_px;
        logic [PIX_W-1:0]   int_val;
        logic [PIX_W-1:0]   grey;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_job;

    typedef enum logic [1:0] {
        BK_FIRST  = 2'b01,
        BK_SECOND = 2'b10
    } t_bk_state;

endpackage

>>> src/set_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module set_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/set_front.sv
// Front pipeline: pixel accept, raster position, grey conversion, line store,
// 3x3 window, Sobel gradients and threshold. Depends on set_pkg and set_ram.
`timescale 1ns / 1ps

module set_front
    import set_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_red,
    input  logic [PIX_W-1:0] i_green,
    input  logic [PIX_W-1:0] i_blue,
    input  logic [JQ_CW-1:0] i_q_count,
    output logic             o_push,
    output t_job             o_job
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int LW = 2 * PIX_W;
    localparam int OW = JQ_CW + 1;

    // clamped frame size
    logic [XW:0] eff_w, wm1;
    logic [YW:0] eff_h, hm1;
    logic [SQ_W-1:0] r_thr_sq;

    // raster position
    logic [XW-1:0] r_col, n_col, cur_c;
    logic [YW-1:0] r_row, n_row, cur_r;

    logic accept;
    logic s0_int, s0_bord, s0_last;
    logic [SUM_W-1:0] s0_sum;

    // stage 1
    logic               r_p1_valid;
    logic [SUM_W-1:0]   r_p1_sum;
    logic [XW-1:0]      r_p1_c;
    logic [COORD_W-1:0] r_p1_row, r_p1_col;
    logic               r_p1_int, r_p1_bord, r_p1_last;
    logic               r_p1_fwd;
    logic [LW-1:0]      r_p1_fwd_data;
    logic [LW-1:0]      ram_rdata, line_word;
    logic [24:0]        grey_prod;
    logic [PIX_W-1:0]   p1_grey;

    // window, [row][col], row 2 is the current line
    logic [PIX_W-1:0] r_win [3][3];

    // stage 2
    logic               r_p2_valid;
    logic [PIX_W-1:0]   r_p2_grey;
    logic [COORD_W-1:0] r_p2_row, r_p2_col;
    logic               r_p2_int, r_p2_bord, r_p2_last;
    logic [9:0]         sum_bot, sum_top, sum_rgt, sum_lft;
    logic signed [GRAD_W-1:0] gx, gy;
    logic [THR_W-1:0]   ax, ay;

    // stage 3
    logic               r_p3_valid;
    logic [PIX_W-1:0]   r_p3_grey, r_p3_center;
    logic [COORD_W-1:0] r_p3_row, r_p3_col;
    logic               r_p3_int, r_p3_bord, r_p3_last;
    logic [THR_W-1:0]   r_p3_ax, r_p3_ay;

    // stage 4
    logic               r_p4_valid;
    logic [PIX_W-1:0]   r_p4_grey, r_p4_center;
    logic [COORD_W-1:0] r_p4_row, r_p4_col;
    logic               r_p4_int, r_p4_bord, r_p4_last;
    logic [SQ_W-1:0]    r_p4_sqx, r_p4_sqy;
    logic               r_p4_hit_x, r_p4_hit_y;
    logic               mag_hit;
    logic [PIX_W-1:0]   int_val;

    logic [OW-1:0] inflight;

    // ---------------------------------------------------------------
    // frame size straight from the registers, so a word right after a write
    // already sees the new size
    always_comb begin
        if (i_cfg.frame_width == '0) begin
            eff_w = (XW+1)'(1);
        end else if (32'(i_cfg.frame_width) > MAX_WIDTH) begin
            eff_w = (XW+1)'(MAX_WIDTH);
        end else begin
            eff_w = (XW+1)'(i_cfg.frame_width);
        end
        if (i_cfg.frame_height == '0) begin
            eff_h = (YW+1)'(1);
        end else if (32'(i_cfg.frame_height) > MAX_HEIGHT) begin
            eff_h = (YW+1)'(MAX_HEIGHT);
        end else begin
            eff_h = (YW+1)'(i_cfg.frame_height);
        end
    end

    assign wm1 = eff_w - (XW+1)'(1);
    assign hm1 = eff_h - (YW+1)'(1);

    always_ff @(posedge i_clk) begin
        r_thr_sq <= SQ_W'(i_cfg.edge_threshold) * SQ_W'(i_cfg.edge_threshold);
    end

    // ---------------------------------------------------------------
    // accept: credit covers every word still in flight
    assign inflight = OW'(r_p1_valid) + OW'(r_p2_valid) + OW'(r_p3_valid) + OW'(r_p4_valid);
    assign o_ready  = (OW'(i_q_count) + inflight) < OW'(JQ_DEPTH);
    assign accept   = i_valid && o_ready;

    always_comb begin
        logic          wrap_c;
        logic [YW:0]   row_a;
        logic [XW:0]   col_p1;
        logic [YW:0]   row_p1;
        // wrap a position left out of range by a shrunk frame
        wrap_c = {1'b0, r_col} >= eff_w;
        row_a  = wrap_c ? ({1'b0, r_row} + (YW+1)'(1)) : {1'b0, r_row};
        cur_r  = (row_a >= eff_h) ? '0 : YW'(row_a);
        cur_c  = wrap_c ? '0 : r_col;

        col_p1 = {1'b0, cur_c} + (XW+1)'(1);
        row_p1 = {1'b0, cur_r} + (YW+1)'(1);
        if (col_p1 >= eff_w) begin
            n_col = '0;
            n_row = (row_p1 >= eff_h) ? '0 : YW'(row_p1);
        end else begin
            n_col = XW'(col_p1);
            n_row = cur_r;
        end

        s0_int  = (cur_r >= YW'(2)) && (cur_c >= XW'(2));
        s0_bord = (cur_r == '0) || ({1'b0, cur_r} == hm1) ||
                  (cur_c == '0) || ({1'b0, cur_c} == wm1);
        s0_last = ({1'b0, cur_r} == hm1) && ({1'b0, cur_c} == wm1);
        s0_sum  = SUM_W'({i_blue, 1'b0}) + SUM_W'(i_blue) +
                  SUM_W'({i_green, 2'b00}) + SUM_W'({i_green, 1'b0}) + SUM_W'(i_red);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------------------------------------------------------
    // line store: upper byte is row r-2, lower byte row r-1
    set_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (r_p1_valid),
        .i_waddr (r_p1_c),
        .i_wdata ({line_word[PIX_W-1:0], p1_grey}),
        .i_re    (accept),
        .i_raddr (cur_c),
        .o_rdata (ram_rdata)
    );

    // a one-column frame reads the column that is being written
    assign line_word = r_p1_fwd ? r_p1_fwd_data : ram_rdata;
    assign grey_prod = 25'(r_p1_sum) * 25'(GREY_RECIP);
    assign p1_grey   = grey_prod[GREY_SHIFT +: PIX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
        end else begin
            r_p1_valid <= accept;
        end
        r_p1_sum      <= s0_sum;
        r_p1_c        <= cur_c;
        r_p1_row      <= COORD_W'(cur_r);
        r_p1_col      <= COORD_W'(cur_c);
        r_p1_int      <= s0_int;
        r_p1_bord     <= s0_bord;
        r_p1_last     <= s0_last;
        r_p1_fwd      <= r_p1_valid && (r_p1_c == cur_c);
        r_p1_fwd_data <= {line_word[PIX_W-1:0], p1_grey};
    end

    // ---------------------------------------------------------------
    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    r_win[k][j] <= '0;
                end
            end
        end else if (r_p1_valid) begin
            for (int k = 0; k < 3; k++) begin
                r_win[k][0] <= r_win[k][1];
                r_win[k][1] <= r_win[k][2];
            end
            r_win[0][2] <= line_word[LW-1:PIX_W];
            r_win[1][2] <= line_word[PIX_W-1:0];
            r_win[2][2] <= p1_grey;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_valid <= 1'b0;
        end else begin
            r_p2_valid <= r_p1_valid;
        end
        r_p2_grey <= p1_grey;
        r_p2_row  <= r_p1_row;
        r_p2_col  <= r_p1_col;
        r_p2_int  <= r_p1_int;
        r_p2_bord <= r_p1_bord;
        r_p2_last <= r_p1_last;
    end

    // ---------------------------------------------------------------
    // Sobel responses on the window of the item in stage 2
    always_comb begin
        sum_bot = 10'(r_win[2][0]) + 10'({r_win[2][1], 1'b0}) + 10'(r_win[2][2]);
        sum_top = 10'(r_win[0][0]) + 10'({r_win[0][1], 1'b0}) + 10'(r_win[0][2]);
        sum_rgt = 10'(r_win[0][2]) + 10'({r_win[1][2], 1'b0}) + 10'(r_win[2][2]);
        sum_lft = 10'(r_win[0][0]) + 10'({r_win[1][0], 1'b0}) + 10'(r_win[2][0]);
        gx = $signed(GRAD_W'(sum_bot)) - $signed(GRAD_W'(sum_top));
        gy = $signed(GRAD_W'(sum_rgt)) - $signed(GRAD_W'(sum_lft));
        ax = gx[GRAD_W-1] ? THR_W'(-gx) : THR_W'(gx);
        ay = gy[GRAD_W-1] ? THR_W'(-gy) : THR_W'(gy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_valid <= 1'b0;
        end else begin
            r_p3_valid <= r_p2_valid;
        end
        r_p3_grey   <= r_p2_grey;
        r_p3_center <= r_win[1][1];
        r_p3_row    <= r_p2_row;
        r_p3_col    <= r_p2_col;
        r_p3_int    <= r_p2_int;
        r_p3_bord   <= r_p2_bord;
        r_p3_last   <= r_p2_last;
        r_p3_ax     <= ax;
        r_p3_ay     <= ay;
    end

    // ---------------------------------------------------------------
    // squares and single-axis compares
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_valid <= 1'b0;
        end else begin
            r_p4_valid <= r_p3_valid;
        end
        r_p4_grey   <= r_p3_grey;
        r_p4_center <= r_p3_center;
        r_p4_row    <= r_p3_row;
        r_p4_col    <= r_p3_col;
        r_p4_int    <= r_p3_int;
        r_p4_bord   <= r_p3_bord;
        r_p4_last   <= r_p3_last;
        r_p4_sqx    <= SQ_W'(r_p3_ax) * SQ_W'(r_p3_ax);
        r_p4_sqy    <= SQ_W'(r_p3_ay) * SQ_W'(r_p3_ay);
        r_p4_hit_x  <= r_p3_ax > i_cfg.edge_threshold;
        r_p4_hit_y  <= r_p3_ay > i_cfg.edge_threshold;
    end

    // ---------------------------------------------------------------
    // magnitude compare, mode select, hand the word to the queue
    assign mag_hit = ((SQ_W+1)'(r_p4_sqx) + (SQ_W+1)'(r_p4_sqy)) > (SQ_W+1)'(r_thr_sq);

    always_comb begin
        case (i_cfg.edge_mode)
            MODE_ROW: int_val = r_p4_hit_x ? PIX_WHITE : PIX_BLACK;
            MODE_MAG: int_val = mag_hit ? PIX_WHITE : PIX_BLACK;
            MODE_COL: int_val = r_p4_hit_y ? PIX_WHITE : PIX_BLACK;
            default:  int_val = r_p4_center;
        endcase
    end

    assign o_push = r_p4_valid && (r_p4_int || r_p4_bord);

    always_comb begin
        o_job.has_int  = r_p4_int;
        o_job.has_bord = r_p4_bord;
        o_job.last_px  = r_p4_last;
        o_job.int_val  = int_val;
        o_job.grey     = r_p4_grey;
        o_job.row      = r_p4_row;
        o_job.col      = r_p4_col;
    end

endmodule

>>> src/set_fifo.sv
// Short job queue between the front pipeline and the result emitter.
// Depends on set_pkg.
`timescale 1ns / 1ps

module set_fifo
    import set_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  t_job             i_job,
    input  logic             i_pop,
    output t_job             o_job,
    output logic             o_empty,
    output logic [JQ_CW-1:0] o_count
);

    t_job             r_mem [JQ_DEPTH];
    logic [JQ_AW-1:0] r_wp, r_rp;
    logic [JQ_CW-1:0] r_cnt;
    logic             do_pop;

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_job   = r_mem[r_rp];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // the front never pushes past its credit, so no full check here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == JQ_AW'(JQ_DEPTH - 1)) ? '0 : r_wp + JQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == JQ_AW'(JQ_DEPTH - 1)) ? '0 : r_rp + JQ_AW'(1);
            end
            r_cnt <= r_cnt + JQ_CW'(i_push) - JQ_CW'(do_pop);
        end
    end

endmodule

>>> src/set_back.sv
// Result emitter: splits each queued job into one or two output words and
// holds them in the output register. Depends on set_pkg.
`timescale 1ns / 1ps

module set_back
    import set_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [PIX_W-1:0]   o_pixel,
    output logic [COORD_W-1:0] o_row,
    output logic [COORD_W-1:0] o_col,
    output logic               o_last_of_item,
    output logic               o_frame_done
);

    t_bk_state          r_state, n_state;
    logic               r_valid, n_valid;
    logic [PIX_W-1:0]   r_pixel, n_pixel;
    logic [COORD_W-1:0] r_row, n_row, r_col, n_col;
    logic               r_last, n_last, r_done, n_done;
    logic               load;

    assign load = (!r_valid || i_ready) && !i_empty;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        n_pixel = r_pixel;
        n_row   = r_row;
        n_col   = r_col;
        n_last  = r_last;
        n_done  = r_done;
        o_pop   = 1'b0;
        if (load) begin
            n_valid = 1'b1;
            if (r_state == BK_FIRST && i_job.has_int) begin
                // interior pixel up-left of the input
                n_pixel = i_job.int_val;
                n_row   = i_job.row - COORD_W'(1);
                n_col   = i_job.col - COORD_W'(1);
                n_last  = !i_job.has_bord;
                n_done  = 1'b0;
                if (i_job.has_bord) begin
                    n_state = BK_SECOND;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_pixel = i_job.grey;
                n_row   = i_job.row;
                n_col   = i_job.col;
                n_last  = 1'b1;
                n_done  = i_job.last_px;
                n_state = BK_FIRST;
                o_pop   = 1'b1;
            end
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_FIRST;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_pixel <= n_pixel;
        r_row   <= n_row;
        r_col   <= n_col;
        r_last  <= n_last;
        r_done  <= n_done;
    end

    assign o_valid        = r_valid;
    assign o_pixel        = r_pixel;
    assign o_row          = r_row;
    assign o_col          = r_col;
    assign o_last_of_item = r_last;
    assign o_frame_done   = r_done;

endmodule

>>> src/sobel_edge_threshold_3x3.sv
// Top level of the 3x3 Sobel edge/threshold block: configuration registers,
// front pipeline, job queue and result emitter. Depends on set_pkg and submodules.
`timescale 1ns / 1ps

// Takes RGB pixels in raster order, one word per clock, and returns grey border
// pixels and thresholded interior pixels (0 or 255, or grey in pass-through) with
// their coordinates. An input word is taken every clock while the 8-entry job
// queue has room; results leave at one word per clock while the output is ready,
// so a pixel that yields two results (right column and bottom row past the first
// two) sends two output words, and a pixel that yields none sends none. The output
// rate, one word per clock at the output register, sets the sustained figure. The
// line store is one RAM of MAX_WIDTH entries, written and read once per pixel.
// Configuration is taken at any time and must only change while no pixel is in
// flight.

module sobel_edge_threshold_3x3
    import set_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
    // result output
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [31:0]           o_m_axis_tdata,  // pixel_value[7:0], out_row[19:8],
                                                   // out_col[31:20]
    output logic                  o_m_axis_tlast,  // frame_done
    output logic                  o_m_axis_tuser   // last_of_item
);

    t_cfg               r_cfg;
    t_job               front_job, head_job;
    logic               push, pop, q_empty;
    logic [JQ_CW-1:0]   q_count;
    logic [PIX_W-1:0]   out_pixel;
    logic [COORD_W-1:0] out_row, out_col;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_width    <= RST_FRAME_WIDTH;
            r_cfg.frame_height   <= RST_FRAME_HEIGHT;
            r_cfg.edge_mode      <= RST_EDGE_MODE;
            r_cfg.edge_threshold <= RST_THRESHOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:    r_cfg.frame_width    <= i_cfg_data;
                CFG_FRAME_HEIGHT:   r_cfg.frame_height   <= i_cfg_data;
                CFG_EDGE_MODE:      r_cfg.edge_mode      <= i_cfg_data[1:0];
                CFG_EDGE_THRESHOLD: r_cfg.edge_threshold <= i_cfg_data[THR_W-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    set_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_red     (i_s_axis_tdata[7:0]),
        .i_green   (i_s_axis_tdata[15:8]),
        .i_blue    (i_s_axis_tdata[23:16]),
        .i_q_count (q_count),
        .o_push    (push),
        .o_job     (front_job)
    );

    set_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    set_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (head_job),
        .i_empty        (q_empty),
        .o_pop          (pop),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_pixel        (out_pixel),
        .o_row          (out_row),
        .o_col          (out_col),
        .o_last_of_item (o_m_axis_tuser),
        .o_frame_done   (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {out_col, out_row, out_pixel};

endmodule

>>> src/set_checker.sv
// Port-level checks for sobel_edge_threshold_3x3, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps

module set_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_m_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic [31:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic        o_m_axis_tuser
);

    // hold a stalled word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("output data changed while stalled");

    // the frame's final pixel is always the last word of its input
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tlast |-> o_m_axis_tuser)
        else $error("frame end on a word that is not last of its input");

    // reset empties the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind sobel_edge_threshold_3x3 set_checker u_set_checker (.*);
